### src/morse_keying_encoder_defines.svh
// Assertion macros shared by the Morse keying encoder RTL.
`ifndef MORSE_KEYING_ENCODER_DEFINES_SVH
`define MORSE_KEYING_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define MKE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define MKE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/mke_pkg.sv
// Types, constants and the character classifier of the Morse keying encoder.
package mke_pkg;

    localparam int CHAR_W     = 8;
    localparam int DIT_W      = 10;
    localparam int DUR_W      = 13;
    localparam int LEN_W      = 3;
    localparam int SYM_MAX    = 6;
    localparam int DESC_DEPTH = 4;
    localparam int DESC_PTR_W = $clog2(DESC_DEPTH);
    localparam int DESC_CNT_W = $clog2(DESC_DEPTH + 1);

    localparam logic [DIT_W-1:0] DIT_RESET = 10'd60;

    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA    = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_HYPHEN   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PERIOD   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 8'h7A;

    // Symbol counts and patterns of a..z, patterns right-aligned, 1 = dah.
    localparam logic [LEN_W-1:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [SYM_MAX-1:0] LETTER_PAT [26] = '{
        6'h01, 6'h08, 6'h0A, 6'h04, 6'h00, 6'h02, 6'h06, 6'h00, 6'h00, 6'h07,
        6'h05, 6'h04, 6'h03, 6'h02, 6'h07, 6'h06, 6'h0D, 6'h02, 6'h00, 6'h01,
        6'h01, 6'h01, 6'h03, 6'h09, 6'h0B, 6'h0C
    };
    // Digits all have five symbols.
    localparam logic [SYM_MAX-1:0] DIGIT_PAT [10] = '{
        6'h1F, 6'h0F, 6'h07, 6'h03, 6'h01, 6'h00, 6'h10, 6'h18, 6'h1C, 6'h1E
    };

    // One classified character: pattern is left-aligned, MSB sent first.
    typedef struct packed {
        logic             space;
        logic [LEN_W-1:0] len;
        logic [SYM_MAX-1:0] pat;
    } mke_desc_t;

    // One key segment as seen on the result ports.
    typedef struct packed {
        logic             key_on;
        logic [DUR_W-1:0] duration;
        logic             last;
    } mke_seg_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } mke_back_state_t;

    function automatic mke_desc_t mke_classify(input logic [CHAR_W-1:0] c);
        mke_desc_t        d;
        logic [LEN_W-1:0] len;
        logic [SYM_MAX-1:0] pat;
        logic [4:0]       li;
        logic [3:0]       di;
        d   = '0;
        len = '0;
        pat = '0;
        li  = 5'(c - CH_LOWER_A);
        di  = 4'(c - CH_ZERO);
        priority if (c == CH_SPACE) begin
            d.space = 1'b1;
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            len = LETTER_LEN[li];
            pat = LETTER_PAT[li];
        end
        else if (c >= CH_ZERO && c <= CH_NINE) begin
            len = 3'd5;
            pat = DIGIT_PAT[di];
        end
        else if (c == CH_QUESTION) begin
            len = 3'd6;
            pat = 6'h0C;
        end
        else if (c == CH_PERIOD) begin
            len = 3'd6;
            pat = 6'h15;
        end
        else if (c == CH_COMMA) begin
            len = 3'd6;
            pat = 6'h33;
        end
        else if (c == CH_HYPHEN) begin
            len = 3'd6;
            pat = 6'h21;
        end
        else if (c == CH_SLASH) begin
            len = 3'd5;
            pat = 6'h12;
        end
        else begin
            len = '0;
            pat = '0;
        end
        d.len = len;
        d.pat = pat << (3'd6 - len);
        return d;
    endfunction

endpackage

### src/mke_front.sv
// Front end: accepts character transactions and classifies them into descriptors.
module mke_front
    import mke_pkg::*;
(
    input  logic              push,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              q_full,
    output logic              q_wr,
    output mke_desc_t         q_wr_desc
);

    // A character is taken whenever the descriptor queue has room.
    assign q_wr      = push & ~q_full;
    assign q_wr_desc = mke_classify(char_code);

endmodule

### src/mke_queue.sv
// Short descriptor queue between the front end and the segment sequencer.
module mke_queue
    import mke_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  mke_desc_t wr_desc,
    output logic      full,
    input  logic      rd,
    output mke_desc_t rd_desc,
    output logic      empty
);

    mke_desc_t             mem [DESC_DEPTH];
    logic [DESC_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [DESC_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [DESC_CNT_W-1:0] count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full    = (count_reg == DESC_CNT_W'(DESC_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr & ~full;
    assign do_rd   = rd & ~empty;
    assign rd_desc = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

### src/mke_back.sv
// Back end: descriptors into key segments, one per cycle unless the output register stalls.
module mke_back
    import mke_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIT_W-1:0] dit,
    input  mke_desc_t        desc,
    input  logic             desc_empty,
    output logic             desc_pop,
    output mke_seg_t         seg_out,
    output logic             seg_empty,
    input  logic             seg_pop
);

    mke_back_state_t    state_reg, state_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [SYM_MAX-1:0] sym_reg, sym_next;
    logic               phase_reg, phase_next;
    mke_seg_t           out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [DUR_W-1:0]   dit1, dit3, dit7;
    logic               cur_valid, cur_space, cur_phase, fire;
    logic [LEN_W-1:0]   cur_rem;
    logic [SYM_MAX-1:0] cur_sym;
    mke_seg_t           seg;
    logic [LEN_W-1:0]   n_rem;
    logic [SYM_MAX-1:0] n_sym;
    logic               n_phase;

    assign dit1 = DUR_W'(dit);
    assign dit3 = DUR_W'({dit, 1'b0}) + DUR_W'(dit);
    assign dit7 = DUR_W'({dit, 3'b000}) - DUR_W'(dit);

    assign seg_out   = out_reg;
    assign seg_empty = ~out_valid_reg;

    always_comb
    begin
        // While idle, the head of the queue is worked on directly.
        cur_valid = (state_reg == BK_RUN) | ~desc_empty;
        cur_space = (state_reg == BK_RUN) ? 1'b0      : desc.space;
        cur_rem   = (state_reg == BK_RUN) ? rem_reg   : desc.len;
        cur_sym   = (state_reg == BK_RUN) ? sym_reg   : desc.pat;
        cur_phase = (state_reg == BK_RUN) ? phase_reg : 1'b0;
        fire      = cur_valid & (~out_valid_reg | seg_pop);
        desc_pop  = fire & (state_reg == BK_IDLE);

        n_rem   = cur_rem;
        n_sym   = cur_sym;
        n_phase = cur_phase;
        priority if (cur_space)
        begin
            seg = '{key_on: 1'b0, duration: dit7, last: 1'b1};
        end
        else if (cur_rem == '0)
        begin
            seg = '{key_on: 1'b0, duration: dit3, last: 1'b1};
        end
        else if (!cur_phase)
        begin
            seg = '{key_on: 1'b1, duration: (cur_sym[SYM_MAX-1] ? dit3 : dit1), last: 1'b0};
            n_phase = 1'b1;
        end
        else
        begin
            seg = '{key_on: 1'b0, duration: dit1, last: 1'b0};
            n_phase = 1'b0;
            n_rem   = cur_rem - 1'b1;
            n_sym   = cur_sym << 1;
        end

        state_next     = state_reg;
        rem_next       = rem_reg;
        sym_next       = sym_reg;
        phase_next     = phase_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~seg_pop;
        if (fire)
        begin
            state_next     = seg.last ? BK_IDLE : BK_RUN;
            rem_next       = n_rem;
            sym_next       = n_sym;
            phase_next     = n_phase;
            out_next       = seg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        sym_reg   <= sym_next;
        phase_reg <= phase_next;
        out_reg   <= out_next;
    end

endmodule

### src/morse_keying_encoder.sv
// Top level of the Morse keying encoder: front end, descriptor queue, sequencer, dit register.
//
// Usage: write one ASCII character per input transaction (push while full is low).
// Each character comes back as a run of key segments on the result queue side:
// key_on, duration_ms and last are valid while empty is low and are taken with pop.
// Letters a-z, digits and ? . , - / give a key-on per symbol (one dit or three)
// each followed by a one-dit key-off, then a three-dit key-off; a space gives a
// single seven-dit key-off; any other code gives a single three-dit key-off.
// The final segment of every character has last set.
// The first segment of a character is written into the descriptor queue and then into
// the result register, from which it can be taken once empty is low.
// A character with n symbols gives 2n+1 segments (1 to 13), which the sequencer
// produces one per cycle while the result register is free or being taken. A four-entry
// descriptor queue lets the input side keep taking characters while the sequencer works.
// The dit length is written through cfg_valid/cfg_ready/cfg_data (always ready) and
// resets to 60 ms. Reset empties the queue and the result register.
// When the receiver stalls, the held segment stays put, the sequencer waits, and
// full rises once the descriptor queue has filled.
module morse_keying_encoder
    import mke_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CHAR_W-1:0] char_code,
    output logic              empty,
    input  logic              pop,
    output logic              key_on,
    output logic [DUR_W-1:0]  duration_ms,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DIT_W-1:0]  cfg_data
);

`include "morse_keying_encoder_defines.svh"

    logic [DIT_W-1:0] dit_reg, dit_next;
    logic             q_wr, q_full, q_empty, q_rd;
    mke_desc_t        q_wr_desc, q_rd_desc;
    mke_seg_t         seg;

    // The dit register accepts a write in every cycle.
    assign cfg_ready = 1'b1;
    assign dit_next  = (cfg_valid && cfg_ready) ? cfg_data : dit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_reg <= DIT_RESET;
        end
        else
        begin
            dit_reg <= dit_next;
        end
    end

    mke_front u_front (
        .push      (push),
        .char_code (char_code),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_wr_desc (q_wr_desc)
    );

    mke_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_desc (q_wr_desc),
        .full    (q_full),
        .rd      (q_rd),
        .rd_desc (q_rd_desc),
        .empty   (q_empty)
    );

    mke_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .dit        (dit_reg),
        .desc       (q_rd_desc),
        .desc_empty (q_empty),
        .desc_pop   (q_rd),
        .seg_out    (seg),
        .seg_empty  (empty),
        .seg_pop    (pop)
    );

    assign full        = q_full;
    assign key_on      = seg.key_on;
    assign duration_ms = seg.duration;
    assign last        = seg.last;

    // The sequencer only takes a descriptor that is actually in the queue.
    `MKE_ASSERT_SAME(a_desc_pop_has_data, q_rd, !q_empty)
    // A character never ends on a key-on segment.
    `MKE_ASSERT_SAME(a_last_is_gap, !empty && last, !key_on)
    // A key-on segment lasts exactly one dit or three.
    `MKE_ASSERT_SAME(a_key_on_length, !empty && key_on,
        (duration_ms == DUR_W'(dit_reg)) ||
        (duration_ms == DUR_W'({dit_reg, 1'b0}) + DUR_W'(dit_reg)))

endmodule

### tb/testbench.sv
// Self-checking testbench for the Morse keying encoder: directed table, then random characters.
module testbench;
    import mke_pkg::*;

    // Clock and reset. Reset is held low from the start and released once.
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ports of the block.
    logic              push;
    logic              full;
    logic [CHAR_W-1:0] char_code;
    logic              empty;
    logic              pop;
    logic              key_on;
    logic [DUR_W-1:0]  duration_ms;
    logic              last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [DIT_W-1:0]  cfg_data;

    morse_keying_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .char_code   (char_code),
        .empty       (empty),
        .pop         (pop),
        .key_on      (key_on),
        .duration_ms (duration_ms),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // One key segment as the testbench expects to see it.
    typedef struct {
        bit             key_on;
        bit [DUR_W-1:0] duration;
        bit             last;
    } key_segment_t;

    // A row of the directed table either sends a character or rewrites the dit length.
    typedef enum {
        ROW_CHAR,
        ROW_DIT
    } row_kind_e;

    typedef struct {
        row_kind_e      kind;
        bit [DIT_W-1:0] arg;
        bit             typed;
        bit [DUR_W-1:0] typed_dur;
    } stim_row_t;

    localparam bit [DIT_W-1:0] DIT_AFTER_RESET = 10'd60;

    // Segments that the block still owes us, oldest first.
    key_segment_t   key_segments_due[$];
    stim_row_t      directed_rows[$];
    // The dit length that the block currently holds, as far as the testbench knows.
    bit [DIT_W-1:0] dit_setting;
    int             mismatch_count = 0;
    // When set, the corresponding side runs flat out with no idle cycles.
    bit             tx_quiet = 1'b0;
    bit             rx_quiet = 1'b0;

    // Dots and dashes of every letter and digit, sent left to right.
    string letter_code [26] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--.."
    };
    string digit_code [10] = '{
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };
    string mark_chars = "?.,-/";

    // Returns the dot/dash string of a character; empty when the code is not mapped.
    function automatic string morse_for(input bit [7:0] c);
        if (c >= "a" && c <= "z")
            return letter_code[c - "a"];
        if (c >= "0" && c <= "9")
            return digit_code[c - "0"];
        case (c)
            "?": return "..--..";
            ".": return ".-.-.-";
            ",": return "--..--";
            "-": return "-....-";
            "/": return "-..-.";
            default: return "";
        endcase
    endfunction

    // Appends the segments that one character produces at the current dit length.
    // Every symbol is a key-on (one dit for a dot, three for a dash) followed by a
    // one-dit key-off, and the character closes with a three-dit key-off. A space is
    // only a seven-dit key-off. An unmapped code leaves just the closing gap.
    function automatic void predict_keying(input bit [7:0] c);
        string          code;
        key_segment_t   seg;
        bit [DUR_W-1:0] dit_units;
        int             i;
        dit_units = dit_setting;
        if (c == " ") begin
            seg.key_on   = 1'b0;
            seg.duration = dit_units * 7;
            seg.last     = 1'b1;
            key_segments_due.push_back(seg);
            return;
        end
        code = morse_for(c);
        for (i = 0; i < code.len(); i++) begin
            seg.key_on   = 1'b1;
            seg.duration = (code[i] == "-") ? dit_units * 3 : dit_units;
            seg.last     = 1'b0;
            key_segments_due.push_back(seg);
            seg.key_on   = 1'b0;
            seg.duration = dit_units;
            key_segments_due.push_back(seg);
        end
        seg.key_on   = 1'b0;
        seg.duration = dit_units * 3;
        seg.last     = 1'b1;
        key_segments_due.push_back(seg);
    endfunction

    // Idle length in cycles: mostly none, sometimes a few, now and then a long one.
    function automatic int pause_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random character: mostly letters and digits, with marks, spaces and arbitrary codes.
    function automatic bit [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'("a" + $urandom_range(0, 25));
        if (r < 67)
            return 8'("0" + $urandom_range(0, 9));
        if (r < 75)
            return mark_chars[$urandom_range(0, 4)];
        if (r < 83)
            return " ";
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_row(input row_kind_e kind, input bit [DIT_W-1:0] arg,
                                    input bit typed, input bit [DUR_W-1:0] typed_dur);
        stim_row_t r;
        r.kind      = kind;
        r.arg       = arg;
        r.typed     = typed;
        r.typed_dur = typed_dur;
        directed_rows.push_back(r);
    endfunction

    // Offers one character and waits for its transaction. A typed row expects a single
    // closing key-off of the given length; any other row is predicted. Push stays high
    // when no gap follows, so back-to-back characters never see push drop.
    task automatic send_char(input bit [7:0] c, input bit typed, input bit [DUR_W-1:0] typed_dur);
        key_segment_t seg;
        int           n;
        push      <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (typed) begin
            seg.key_on   = 1'b0;
            seg.duration = typed_dur;
            seg.last     = 1'b1;
            key_segments_due.push_back(seg);
        end
        else begin
            predict_keying(c);
        end
        n = pause_len(tx_quiet);
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Holds the sender off until every segment owed has been taken. Since every
    // character produces at least one segment, the block is idle once this returns.
    task automatic drain_results();
        push <= 1'b0;
        while (key_segments_due.size() != 0)
            @(posedge clk);
    endtask

    // Rewrites the dit length while the block is idle.
    task automatic write_dit(input bit [DIT_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        dit_setting = v;
    endtask

    // Result side: checks every accepted segment against the oldest one owed and
    // drives pop with random stalls. A stall can start at any cycle, so it lands both
    // in the middle of a character and while the queue is empty.
    int rx_hold = 0;

    always @(posedge clk)
    begin : result_side
        key_segment_t want;
        bit           next_pop;
        if (rst_n && pop && !empty) begin
            if (key_segments_due.size() == 0) begin
                $display("%0t: segment key_on=%0d duration_ms=%0d last=%0d with none expected",
                         $time, key_on, duration_ms, last);
                mismatch_count++;
            end
            else begin
                want = key_segments_due.pop_front();
                if (key_on !== want.key_on) begin
                    $display("%0t: key_on expected %0d, got %0d", $time, want.key_on, key_on);
                    mismatch_count++;
                end
                if (duration_ms !== want.duration) begin
                    $display("%0t: duration_ms expected %0d, got %0d",
                             $time, want.duration, duration_ms);
                    mismatch_count++;
                end
                if (last !== want.last) begin
                    $display("%0t: last expected %0d, got %0d", $time, want.last, last);
                    mismatch_count++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold  = rx_hold - 1;
            next_pop = (rx_hold == 0);
        end
        else begin
            rx_hold  = pause_len(rx_quiet);
            next_pop = (rx_hold == 0);
        end
        pop <= next_pop;
    end

    // Main sequence: reset, directed table, random phases at several dit lengths, drain.
    initial
    begin : stimulus
        int             phase;
        int             k;
        bit [DIT_W-1:0] v;
        rst_n       = 1'b0;
        push        = 1'b0;
        char_code   = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        dit_setting = DIT_AFTER_RESET;

        // Reset-value rows: space and unmapped codes at the default 60 ms dit.
        add_row(ROW_CHAR, " ", 1'b1, 13'd420);
        add_row(ROW_CHAR, 8'h00, 1'b1, 13'd180);
        add_row(ROW_CHAR, 8'hFF, 1'b1, 13'd180);
        add_row(ROW_CHAR, "A", 1'b1, 13'd180);
        // One-symbol letters, both ends of the alphabet and digits, and every mark.
        add_row(ROW_CHAR, "e", 1'b0, '0);
        add_row(ROW_CHAR, "t", 1'b0, '0);
        add_row(ROW_CHAR, "a", 1'b0, '0);
        add_row(ROW_CHAR, "z", 1'b0, '0);
        add_row(ROW_CHAR, "0", 1'b0, '0);
        add_row(ROW_CHAR, "9", 1'b0, '0);
        add_row(ROW_CHAR, "?", 1'b0, '0);
        add_row(ROW_CHAR, ".", 1'b0, '0);
        add_row(ROW_CHAR, ",", 1'b0, '0);
        add_row(ROW_CHAR, "-", 1'b0, '0);
        add_row(ROW_CHAR, "/", 1'b0, '0);
        // Shortest dit.
        add_row(ROW_DIT, 10'd1, 1'b0, '0);
        add_row(ROW_CHAR, " ", 1'b1, 13'd7);
        add_row(ROW_CHAR, "h", 1'b0, '0);
        // Longest dit: the space gives the widest duration the block produces.
        add_row(ROW_DIT, 10'd1023, 1'b0, '0);
        add_row(ROW_CHAR, " ", 1'b1, 13'd7161);
        add_row(ROW_CHAR, "-", 1'b0, '0);
        // A zero dit still emits every segment, each with zero duration.
        add_row(ROW_DIT, 10'd0, 1'b0, '0);
        add_row(ROW_CHAR, "p", 1'b0, '0);
        add_row(ROW_CHAR, " ", 1'b1, 13'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_DIT)
                write_dit(directed_rows[i].arg);
            else
                send_char(directed_rows[i].arg[7:0], directed_rows[i].typed,
                          directed_rows[i].typed_dur);
        end

        // Random part. The third phase runs both sides with no idling at all, and the
        // first one stops halfway until every owed segment has come back.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       v = 10'($urandom_range(2, 1022));
                1:       v = DIT_AFTER_RESET;
                2:       v = 10'($urandom_range(1, 15));
                default: v = 10'd1023;
            endcase
            write_dit(v);
            tx_quiet = (phase == 2);
            rx_quiet = (phase == 2);
            for (k = 0; k < 22; k++) begin
                if (phase == 0 && k == 11)
                    drain_results();
                send_char(random_char(), 1'b0, '0);
            end
        end
        rx_quiet = 1'b0;

        // Let everything owed come back, then give the block a few more cycles in
        // which any stray segment would be caught.
        drain_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("morse_keying_encoder: match");
        else
            $display("morse_keying_encoder: mismatch");
        $finish;
    end

    // Watchdog, sized well above the slowest legal run of this stimulus.
    initial
    begin : watchdog
        #4000000;
        $display("morse_keying_encoder: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/mke_pkg.sv
src/mke_front.sv
src/mke_queue.sv
src/mke_back.sv
src/morse_keying_encoder.sv
tb/testbench.sv
